>>> hdl/mfpd_pkg.sv
// Shared types and constants for the median-filtered position drive.
`default_nettype none
package mfpd_pkg;

	localparam int TGT_W      = 10;
	localparam int THR_W      = 10;
	localparam int DUTY_W     = 8;
	localparam int JOG_W      = 16;
	localparam int DIR_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY  = 3'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_JOG    = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0]  hysteresis;
		logic [THR_W-1:0]  far_threshold;
		logic [THR_W-1:0]  near_threshold;
		logic [DUTY_W-1:0] full_duty;
		logic [DUTY_W-1:0] slow_duty;
	} cfg_t;

endpackage
`default_nettype wire

>>> hdl/mfpd_cfg.sv
// Configuration register file for the position drive thresholds and duties.
`default_nettype none
module mfpd_cfg
	import mfpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis     <= THR_W'(1);
			cfg_q.far_threshold  <= THR_W'(15);
			cfg_q.near_threshold <= THR_W'(1);
			cfg_q.full_duty      <= DUTY_W'(255);
			cfg_q.slow_duty      <= DUTY_W'(150);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HYSTERESIS: cfg_q.hysteresis     <= cfg_data[THR_W-1:0];
				CFG_FAR_THR:    cfg_q.far_threshold  <= cfg_data[THR_W-1:0];
				CFG_NEAR_THR:   cfg_q.near_threshold <= cfg_data[THR_W-1:0];
				CFG_FULL_DUTY:  cfg_q.full_duty      <= cfg_data[DUTY_W-1:0];
				CFG_SLOW_DUTY:  cfg_q.slow_duty      <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/mfpd_sort.sv
// Window memory with sorted insertion and median readout.
`default_nettype none
module mfpd_sort
	import mfpd_pkg::*;
#(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        busy,
	output logic                        med_valid,
	input  wire logic                   med_take,
	output logic [SAMPLE_BITS-1:0]      med
);

	localparam int AW = $clog2(WINDOW);
	localparam logic [AW-1:0] MID  = AW'(WINDOW / 2);
	localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PLACE,
		ST_MEDR,
		ST_MEDV
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] j_q, j_d;
	logic [AW-1:0] fill_q, fill_d;
	logic [SAMPLE_BITS-1:0] v_q, v_d;

	logic [SAMPLE_BITS-1:0] mem_q [WINDOW];
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic we, re, finish;
	logic [AW-1:0] wa, ra;
	logic [SAMPLE_BITS-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem_q[ra];
		end
	end

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		fill_d  = fill_q;
		v_d     = v_q;
		we      = 1'b0;
		wa      = j_q;
		wd      = v_q;
		re      = 1'b0;
		ra      = j_q - AW'(1);
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					v_d = sample;
					j_d = fill_q;
					if (fill_q == '0) begin
						we     = 1'b1;
						wa     = '0;
						wd     = sample;
						finish = 1'b1;
					end else begin
						re      = 1'b1;
						ra      = fill_q - AW'(1);
						state_d = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				we = 1'b1;
				wa = j_q;
				if (rdata_q > v_q) begin
					wd  = rdata_q;
					j_d = j_q - AW'(1);
					if (j_q == AW'(1)) begin
						state_d = ST_PLACE;
					end else begin
						re = 1'b1;
						ra = j_q - AW'(2);
					end
				end else begin
					wd     = v_q;
					finish = 1'b1;
				end
			end
			ST_PLACE: begin
				we     = 1'b1;
				wa     = '0;
				wd     = v_q;
				finish = 1'b1;
			end
			ST_MEDR: begin
				re      = 1'b1;
				ra      = MID;
				state_d = ST_MEDV;
			end
			ST_MEDV: begin
				if (med_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (finish) begin
			if (fill_q == LAST) begin
				fill_d  = '0;
				state_d = ST_MEDR;
			end else begin
				fill_d  = fill_q + AW'(1);
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			j_q     <= '0;
			v_q     <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			j_q     <= j_d;
			v_q     <= v_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign med_valid = (state_q == ST_MEDV);
	assign med       = rdata_q;

endmodule
`default_nettype wire

>>> hdl/median_filtered_position_drive.sv
// Median-filtered bang-bang position drive, top level.
// The first sample of a window is written straight into the memory; a later sample is compared with
// the stored entries from the top down, each larger one shifted up a place, and is then written in.
// After the window's last sample the median is read (ST_MEDR, ST_MEDV) before the result register
// loads; a result that waits under stall holds the input off until it is taken.
// Reset clears control state, the fill count, held direction and jog count, not the memory.
`default_nettype none
module median_filtered_position_drive
	import mfpd_pkg::*;
#(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic                   op,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [TGT_W-1:0]       target,
	input  wire logic signed [JOG_W-1:0] jog_count,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [DIR_W-1:0]            direction,
	output logic [DUTY_W-1:0]           duty,
	output logic [SAMPLE_BITS-1:0]      position,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int EW = ((SAMPLE_BITS > TGT_W) ? SAMPLE_BITS : TGT_W) + 2;

	cfg_t cfg;
	logic busy, med_valid, med_take, accept, start;
	logic [SAMPLE_BITS-1:0] med;

	logic [TGT_W-1:0]        tgt_q;
	logic signed [JOG_W-1:0] jog_q, jog_d;
	logic [DIR_W-1:0]        held_q, held_d;
	logic [DUTY_W-1:0]       duty_d;
	logic                    out_valid_q;
	logic [DIR_W-1:0]        dir_q;
	logic [DUTY_W-1:0]       duty_q;
	logic [SAMPLE_BITS-1:0]  pos_q;

	logic [EW-1:0] p_e, t_e, h_e, mag;

	mfpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mfpd_sort #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sort (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (sample),
		.busy      (busy),
		.med_valid (med_valid),
		.med_take  (med_take),
		.med       (med)
	);

	assign item_stall = busy;
	assign accept     = item_valid && !item_stall;
	assign start      = accept && (op == OP_SAMPLE);
	assign med_take   = med_valid && (!out_valid_q || !result_stall);

	always_comb begin
		p_e    = EW'(med);
		t_e    = EW'(tgt_q);
		h_e    = EW'(cfg.hysteresis);
		mag    = (p_e >= t_e) ? (p_e - t_e) : (t_e - p_e);
		held_d = held_q;
		jog_d  = jog_q;
		duty_d = '0;
		if (jog_q > 0) begin
			held_d = DIR_CW;
			duty_d = cfg.full_duty;
			jog_d  = jog_q - JOG_W'(1);
		end else if (jog_q < 0) begin
			held_d = DIR_CCW;
			duty_d = cfg.full_duty;
			jog_d  = jog_q + JOG_W'(1);
		end else begin
			if ((p_e + h_e) < t_e) begin
				held_d = DIR_CW;
			end else if (p_e > (t_e + h_e)) begin
				held_d = DIR_CCW;
			end
			if (mag > EW'(cfg.far_threshold)) begin
				duty_d = cfg.full_duty;
			end else if (mag > EW'(cfg.near_threshold)) begin
				duty_d = cfg.slow_duty;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jog_q       <= '0;
			held_q      <= DIR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (op == OP_JOG)) begin
				jog_q <= jog_count;
			end
			if (med_take) begin
				jog_q       <= jog_d;
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tgt_q <= target;
		end
		if (med_take) begin
			dir_q  <= held_d;
			duty_q <= duty_d;
			pos_q  <= med;
		end
	end

	assign result_valid = out_valid_q;
	assign direction    = dir_q;
	assign duty         = duty_q;
	assign position     = pos_q;

endmodule
`default_nettype wire
